// ----- rtl/tfas_pkg.sv -----
// Shared types and constants of the tile frame animation sequencer.
package tfas_pkg;

    localparam int TILE_W  = 16;
    localparam int DUR_W   = 16;
    localparam int INDEX_W = 6;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int TIME_W  = 32;
    localparam int ELAP_W  = 16;
    localparam int MODE_W  = 2;

    // frame index is 6 bits wide, so no more than this many slots are reachable
    localparam int SLOT_LIMIT     = 2 ** INDEX_W;
    localparam int MAX_FRAMES_DEF = 64;

    // item kinds carried on s_tuser
    localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    // configuration register indexes (paddr[2])
    localparam logic REG_FRAME_COUNT = 1'b0;
    localparam logic REG_BASE_TILE   = 1'b1;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 24;

    typedef struct packed {
        logic [TILE_W-1:0] tile;
        logic [DUR_W-1:0]  dur;
    } frame_entry_t;

endpackage

// ----- rtl/tfas_rem_unit.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module tfas_rem_unit #(
    parameter int SUM_W = 22
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [tfas_pkg::TIME_W-1:0] dividend,
    input  logic [SUM_W-1:0]          divisor,
    output logic                      done,
    output logic [SUM_W-1:0]          rem
);

    localparam int CNT_W = $clog2(tfas_pkg::TIME_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tfas_pkg::TIME_W - 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [tfas_pkg::TIME_W-1:0] dvd_reg;
    logic [SUM_W-1:0]            rem_reg;
    logic [SUM_W-1:0]            rem_next;
    logic [SUM_W:0]              trial;

    // remainder stays below the divisor, so the trial value fits one extra bit
    always_comb begin
        trial = {rem_reg, dvd_reg[tfas_pkg::TIME_W-1]};
        if (trial >= {1'b0, divisor}) begin
            rem_next = SUM_W'(trial - {1'b0, divisor});
        end else begin
            rem_next = trial[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[tfas_pkg::TIME_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/tile_frame_animation_sequencer_unit.sv -----
// Top level: frame table memory, sequencing state machine and APB registers.
//
//   channel  | direction | payload (low bit first)
//   s_       | in        | tuser: mode; tdata: elapsed_ms, frame_slot, frame_tile,
//            |           |   frame_duration
//   m_       | out       | tdata: tile_changed, frame_index, shown_tile
//   apb      | in/out    | reg 0 frame_count @0x0, reg 1 base_tile_id @0x4
//
// Write, the unused kind and an advance with no frames in use go from BEFORE to FIN; restart passes AFTER.
// An advance goes through BEFORE and WALK, stepping frames through the table port,
// re-sums durations in SUM first after a table or count change,
// and folds whole passes in the remainder unit (DIV) on a long advance.
// Synchronous active-low reset; the frame table is not cleared.
// A new item is taken while a result waits on m_; it stalls before its own result.
module tile_frame_animation_sequencer_unit #(
    parameter int MAX_FRAMES = tfas_pkg::MAX_FRAMES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] elapsed_ms, [21:16] frame_slot, [37:22] frame_tile,
    // [53:38] frame_duration, [55:54] zero
    input  logic [tfas_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] mode
    input  logic [tfas_pkg::MODE_W-1:0]   s_tuser,
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] tile_changed, [6:1] frame_index, [22:7] shown_tile, [23] zero
    output logic [tfas_pkg::M_DATA_W-1:0] m_tdata,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tfas_pkg::APB_AW-1:0]   paddr,
    input  logic [tfas_pkg::APB_DW-1:0]   pwdata,
    output logic [tfas_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int DEPTH = (MAX_FRAMES < tfas_pkg::SLOT_LIMIT) ? MAX_FRAMES
                                                                : tfas_pkg::SLOT_LIMIT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = tfas_pkg::DUR_W + ((DEPTH > 1) ? $clog2(DEPTH) : 0);
    localparam logic [tfas_pkg::COUNT_W-1:0] DEPTH_C = tfas_pkg::COUNT_W'(DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_BEFORE = 7'b0000010,
        ST_SUM    = 7'b0000100,
        ST_WALK   = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_AFTER  = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // latched item
    logic [tfas_pkg::MODE_W-1:0]  mode_reg;
    logic [tfas_pkg::ELAP_W-1:0]  elapsed_reg;
    logic [tfas_pkg::SLOT_W-1:0]  slot_reg;
    logic [tfas_pkg::TILE_W-1:0]  ftile_reg;
    logic [tfas_pkg::DUR_W-1:0]   fdur_reg;

    logic [tfas_pkg::COUNT_W-1:0] frame_count_reg;
    logic [tfas_pkg::TILE_W-1:0]  base_tile_reg;

    logic [tfas_pkg::INDEX_W-1:0] cur_reg, cur_next;
    logic [tfas_pkg::TIME_W-1:0]  unused_reg, unused_next;
    logic [tfas_pkg::TILE_W-1:0]  before_reg, before_next;
    logic [tfas_pkg::TILE_W-1:0]  after_reg, after_next;
    logic [SUM_W-1:0]             sum_reg, sum_next;
    logic                         allnz_reg, allnz_next;
    logic                         sum_valid_reg, sum_valid_next;
    logic [tfas_pkg::COUNT_W-1:0] sum_idx_reg, sum_idx_next;
    logic                         pend_reg, pend_next;
    logic                         reduced_reg, reduced_next;

    logic                         m_tvalid_reg;
    logic [tfas_pkg::M_DATA_W-1:0] m_data_reg;

    // frame table
    tfas_pkg::frame_entry_t       frame_mem [DEPTH];
    tfas_pkg::frame_entry_t       rdata_reg;
    logic [AW-1:0]                rd_addr;
    logic                         wr_en;
    logic                         sum_issue;

    logic                         s_accept;
    logic                         out_load;
    logic                         cfg_wr;
    logic [tfas_pkg::COUNT_W-1:0] n_use;
    logic                         slot_ok;
    logic [tfas_pkg::COUNT_W-1:0] cur_inc;
    logic [tfas_pkg::TIME_W:0]    add_w;
    logic [tfas_pkg::TIME_W-1:0]  unused_sat;

    logic                         div_start;
    logic                         div_done;
    logic [SUM_W-1:0]             div_rem;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    assign n_use   = (frame_count_reg < DEPTH_C) ? frame_count_reg : DEPTH_C;
    assign slot_ok = ({1'b0, slot_reg} < DEPTH_C);
    assign cur_inc = {1'b0, cur_reg} + 1'b1;
    assign add_w   = {1'b0, unused_reg} + (tfas_pkg::TIME_W + 1)'(elapsed_reg);
    assign unused_sat = add_w[tfas_pkg::TIME_W] ? '1 : add_w[tfas_pkg::TIME_W-1:0];

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        unused_next    = unused_reg;
        before_next    = before_reg;
        after_next     = after_reg;
        sum_next       = sum_reg;
        allnz_next     = allnz_reg;
        sum_valid_next = sum_valid_reg;
        sum_idx_next   = sum_idx_reg;
        pend_next      = pend_reg;
        reduced_next   = reduced_reg;
        wr_en          = 1'b0;
        div_start      = 1'b0;
        sum_issue      = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_BEFORE;
                end
            end
            ST_BEFORE: begin
                before_next = (n_use == '0) ? base_tile_reg : rdata_reg.tile;
                case (mode_reg)
                    tfas_pkg::MODE_ADVANCE: begin
                        if (n_use == '0) begin
                            after_next = before_next;
                            state_next = ST_FIN;
                        end else begin
                            unused_next  = unused_sat;
                            reduced_next = 1'b0;
                            if (sum_valid_reg) begin
                                state_next = ST_WALK;
                            end else begin
                                sum_next     = '0;
                                allnz_next   = 1'b1;
                                sum_idx_next = '0;
                                pend_next    = 1'b0;
                                state_next   = ST_SUM;
                            end
                        end
                    end
                    tfas_pkg::MODE_WRITE: begin
                        wr_en = slot_ok;
                        if (slot_ok) begin
                            sum_valid_next = 1'b0;
                        end
                        if (n_use == '0) begin
                            after_next = base_tile_reg;
                        end else if (slot_ok && slot_reg == cur_reg) begin
                            after_next = ftile_reg;
                        end else begin
                            after_next = rdata_reg.tile;
                        end
                        state_next = ST_FIN;
                    end
                    tfas_pkg::MODE_RESTART: begin
                        if (n_use != '0) begin
                            cur_next    = '0;
                            unused_next = '0;
                        end
                        state_next = ST_AFTER;
                    end
                    default: begin
                        after_next = before_next;
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_AFTER: begin
                after_next = (n_use == '0) ? base_tile_reg : rdata_reg.tile;
                state_next = ST_FIN;
            end
            ST_SUM: begin
                // read data is registered, so it arrives in the cycle after the address is issued
                if (pend_reg) begin
                    sum_next   = sum_reg + SUM_W'(rdata_reg.dur);
                    allnz_next = allnz_reg && (rdata_reg.dur != '0);
                end
                if (sum_idx_reg < n_use) begin
                    sum_issue    = 1'b1;
                    sum_idx_next = sum_idx_reg + 1'b1;
                    pend_next    = 1'b1;
                end else begin
                    pend_next      = 1'b0;
                    sum_valid_next = 1'b1;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK: begin
                if (rdata_reg.dur == '0 ||
                    unused_reg <= tfas_pkg::TIME_W'(rdata_reg.dur)) begin
                    after_next = rdata_reg.tile;
                    state_next = ST_FIN;
                end else if (!reduced_reg && allnz_reg && ({1'b0, cur_reg} < n_use) &&
                             unused_reg > tfas_pkg::TIME_W'(sum_reg)) begin
                    // fold whole passes through the table in one go
                    div_start    = 1'b1;
                    reduced_next = 1'b1;
                    state_next   = ST_DIV;
                end else begin
                    unused_next = unused_reg - tfas_pkg::TIME_W'(rdata_reg.dur);
                    cur_next    = (cur_inc >= n_use) ? '0 : cur_inc[tfas_pkg::INDEX_W-1:0];
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    unused_next = tfas_pkg::TIME_W'(div_rem) + 1'b1;
                    state_next  = ST_WALK;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // the table port reads the issued sum index, else the index cur_reg will hold next cycle
        rd_addr = sum_issue ? sum_idx_reg[AW-1:0] : cur_next[AW-1:0];
    end

    tfas_rem_unit #(
        .SUM_W(SUM_W)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (unused_reg - 1'b1),
        .divisor  (sum_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    // frame table memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_mem[slot_reg[AW-1:0]] <= '{tile: ftile_reg, dur: fdur_reg};
        end
        rdata_reg <= frame_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cur_reg         <= '0;
            unused_reg      <= '0;
            sum_valid_reg   <= 1'b0;
            pend_reg        <= 1'b0;
            reduced_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            frame_count_reg <= '0;
            base_tile_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            unused_reg  <= unused_next;
            pend_reg    <= pend_next;
            reduced_reg <= reduced_next;

            if (cfg_wr && paddr[2] == tfas_pkg::REG_FRAME_COUNT) begin
                frame_count_reg <= pwdata[tfas_pkg::COUNT_W-1:0];
                sum_valid_reg   <= 1'b0;
            end else begin
                sum_valid_reg <= sum_valid_next;
            end
            if (cfg_wr && paddr[2] == tfas_pkg::REG_BASE_TILE) begin
                base_tile_reg <= pwdata[tfas_pkg::TILE_W-1:0];
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        before_reg  <= before_next;
        after_reg   <= after_next;
        sum_reg     <= sum_next;
        allnz_reg   <= allnz_next;
        sum_idx_reg <= sum_idx_next;
        if (s_accept) begin
            mode_reg    <= s_tuser;
            elapsed_reg <= s_tdata[15:0];
            slot_reg    <= s_tdata[21:16];
            ftile_reg   <= s_tdata[37:22];
            fdur_reg    <= s_tdata[53:38];
        end
        if (out_load) begin
            m_data_reg <= {1'b0, after_reg, cur_reg, (before_reg != after_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        unique case (paddr[2])
            tfas_pkg::REG_FRAME_COUNT:
                prdata = tfas_pkg::APB_DW'(frame_count_reg);
            tfas_pkg::REG_BASE_TILE:
                prdata = tfas_pkg::APB_DW'(base_tile_reg);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the tile frame animation sequencer.
`timescale 1ns / 100ps

module tb_top;
    import tfas_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = 64;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [ELAP_W-1:0]  elapsed;
        logic [SLOT_W-1:0]  slot;
        logic [TILE_W-1:0]  tile;
        logic [DUR_W-1:0]   dur;
    } anim_item_t;

    typedef struct {
        logic               changed;
        logic [INDEX_W-1:0] index;
        logic [TILE_W-1:0]  shown;
    } anim_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    tile_frame_animation_sequencer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // animation state mirror
    logic [TILE_W-1:0]  frame_tile_mem [TABLE_DEPTH];
    logic [DUR_W-1:0]   frame_dur_mem  [TABLE_DEPTH];
    logic [INDEX_W-1:0] cur_index = '0;
    logic [TIME_W-1:0]  spare_ms = '0;
    logic [COUNT_W-1:0] cfg_count;
    logic [TILE_W-1:0]  cfg_base;

    anim_item_t   stim_queue [$];
    anim_result_t expected_results [$];
    anim_item_t   cur_item;
    idle_mode_t   idle_mode;
    int           mismatches = 0;

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic int frames_in_use();
        return (cfg_count < TABLE_DEPTH) ? int'(cfg_count) : TABLE_DEPTH;
    endfunction

    function automatic logic [TILE_W-1:0] displayed_tile();
        return (frames_in_use() == 0) ? cfg_base : frame_tile_mem[cur_index];
    endfunction

    function automatic void advance_time(logic [ELAP_W-1:0] ms);
        int          n;
        logic [32:0] acc;
        logic [31:0] total;
        logic [31:0] d;
        bit          all_set;
        bit          folded;
        n = frames_in_use();
        if (n == 0)
            return;
        acc = {1'b0, spare_ms} + ms;
        spare_ms = acc[32] ? '1 : acc[31:0];
        total = 0;
        all_set = 1'b1;
        folded = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (frame_dur_mem[i] == 0)
                all_set = 1'b0;
            total += frame_dur_mem[i];
        end
        forever begin
            d = frame_dur_mem[cur_index];
            if (d == 0 || spare_ms <= d)
                break;
            // whole passes through the table collapse into a remainder
            if (!folded && all_set && int'(cur_index) < n && spare_ms > total) begin
                spare_ms = ((spare_ms - 1) % total) + 1;
                folded = 1'b1;
                continue;
            end
            spare_ms -= d;
            cur_index = (int'(cur_index) + 1 >= n) ? '0 : cur_index + 1'b1;
        end
    endfunction

    function automatic anim_result_t apply_item(anim_item_t it);
        anim_result_t r;
        logic [TILE_W-1:0] was_shown;
        was_shown = displayed_tile();
        case (it.mode)
            MODE_ADVANCE: advance_time(it.elapsed);
            MODE_WRITE: begin
                frame_tile_mem[it.slot] = it.tile;
                frame_dur_mem[it.slot]  = it.dur;
            end
            MODE_RESTART: begin
                if (frames_in_use() != 0) begin
                    cur_index = '0;
                    spare_ms  = '0;
                end
            end
            default: ;
        endcase
        r.shown   = displayed_tile();
        r.changed = (r.shown != was_shown);
        r.index   = cur_index;
        return r;
    endfunction

    function automatic bit hold_sender();
        if (idle_mode == IDLE_SENDER)
            return $urandom_range(99) < 65;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(99) < 25;
        return 1'b0;
    endfunction

    function automatic bit stall_receiver();
        if (idle_mode == IDLE_RECEIVER)
            return $urandom_range(99) < 65;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(99) < 25;
        return 1'b0;
    endfunction

    // input driver
    always @(posedge aclk) begin : drive_items
        anim_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_item(cur_item));
            if (!s_tvalid || s_tready) begin
                if (stim_queue.size() != 0 && !hold_sender()) begin
                    nxt = stim_queue.pop_front();
                    cur_item <= nxt;
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.mode;
                    s_tdata  <= {2'b00, nxt.dur, nxt.tile, nxt.slot, nxt.elapsed};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : check_results
        anim_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result transfer, tdata %h", $time, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want.changed) begin
                        mismatches++;
                        $display("%0t: tile_changed expected %0d actual %0d",
                                 $time, want.changed, m_tdata[0]);
                    end
                    if (m_tdata[6:1] !== want.index) begin
                        mismatches++;
                        $display("%0t: frame_index expected %0d actual %0d",
                                 $time, want.index, m_tdata[6:1]);
                    end
                    if (m_tdata[22:7] !== want.shown) begin
                        mismatches++;
                        $display("%0t: shown_tile expected %h actual %h",
                                 $time, want.shown, m_tdata[22:7]);
                    end
                end
            end
            m_tready <= !stall_receiver();
        end
    end

    // register write followed by a read-back
    task automatic reg_access(logic idx, logic [APB_DW-1:0] val);
        logic [APB_DW-1:0] held;
        held = (idx == REG_FRAME_COUNT) ? (val & 32'h7F) : (val & 32'hFFFF);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == REG_FRAME_COUNT)
            cfg_count = held[COUNT_W-1:0];
        else
            cfg_base = held[TILE_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== held) begin
            mismatches++;
            $display("%0t: register %0d read expected %h actual %h",
                     $time, idx, held, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (stim_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic push_item(logic [MODE_W-1:0] mode, logic [ELAP_W-1:0] elapsed,
                             logic [SLOT_W-1:0] slot, logic [TILE_W-1:0] tile,
                             logic [DUR_W-1:0] dur);
        anim_item_t it;
        it.mode    = mode;
        it.elapsed = elapsed;
        it.slot    = slot;
        it.tile    = tile;
        it.dur     = dur;
        stim_queue.push_back(it);
    endtask

    function automatic logic [DUR_W-1:0] pick_duration(bit nonzero);
        int r;
        r = $urandom_range(99);
        if (r < 10 && !nonzero)
            return '0;
        if (r < 80)
            return DUR_W'($urandom_range(1, 40));
        return DUR_W'($urandom_range(1, 65535));
    endfunction

    task automatic push_random(int n);
        int r;
        logic [ELAP_W-1:0] ms;
        logic [SLOT_W-1:0] slot;
        r = $urandom_range(99);
        if ($urandom_range(99) < 50)
            ms = ELAP_W'($urandom_range(0, 64));
        else if ($urandom_range(99) < 60)
            ms = ELAP_W'($urandom_range(0, 1000));
        else
            ms = ELAP_W'($urandom_range(0, 65535));
        if (n > 0 && $urandom_range(99) < 75)
            slot = SLOT_W'($urandom_range(0, n - 1));
        else
            slot = SLOT_W'($urandom_range(0, 63));
        if (r < 55)
            push_item(MODE_ADVANCE, ms, slot, TILE_W'($urandom), pick_duration(1'b0));
        else if (r < 80)
            push_item(MODE_WRITE, ms, slot, TILE_W'($urandom), pick_duration(1'b0));
        else if (r < 92)
            push_item(MODE_RESTART, ms, slot, TILE_W'($urandom), pick_duration(1'b0));
        else
            push_item(MODE_UNUSED, ms, slot, TILE_W'($urandom), pick_duration(1'b0));
    endtask

    initial begin
        #8_000_000;
        $display("tile_frame_animation_sequencer_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        int  count;
        int  reload;
        bit  no_holds;
        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        idle_mode = IDLE_NONE;
        cfg_count = '0;
        cfg_base  = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // not animated: base tile shown, index kept
        push_item(MODE_ADVANCE, 16'd0, '0, '0, '0);
        push_item(MODE_ADVANCE, 16'hFFFF, '0, '0, '0);
        push_item(MODE_RESTART, '0, '0, '0, '0);
        push_item(MODE_UNUSED, '1, '1, '1, '1);
        // load every slot so no unwritten entry is ever read
        push_item(MODE_WRITE, '0, 6'd0, 16'hFFFF, 16'hFFFF);
        push_item(MODE_WRITE, '0, 6'd1, 16'h0000, 16'd1);
        for (int s = 2; s < TABLE_DEPTH - 1; s++)
            push_item(MODE_WRITE, '0, SLOT_W'(s), TILE_W'($urandom),
                      DUR_W'($urandom_range(1, 30)));
        push_item(MODE_WRITE, '0, 6'd63, 16'h5A5A, 16'd0);
        wait_drained();

        reg_access(REG_BASE_TILE, 32'h0000FFFF);
        reg_access(REG_FRAME_COUNT, 32'd64);
        // time equal to the duration does not step; one more ms does
        push_item(MODE_ADVANCE, 16'hFFFF, '0, '0, '0);
        push_item(MODE_ADVANCE, 16'd1, '0, '0, '0);
        push_item(MODE_ADVANCE, 16'd0, '0, '0, '0);
        push_item(MODE_RESTART, '0, '0, '0, '0);
        // writes to the shown slot: new tile, then the same tile again
        push_item(MODE_WRITE, '0, 6'd0, 16'h1234, 16'd3);
        push_item(MODE_WRITE, '0, 6'd0, 16'h1234, 16'd3);
        push_item(MODE_ADVANCE, 16'd300, '0, '0, '0);
        push_item(MODE_ADVANCE, 16'd300, '0, '0, '0);
        push_item(MODE_UNUSED, '0, '0, '0, '0);
        wait_drained();

        // lowered count leaves the index beyond it
        reg_access(REG_FRAME_COUNT, 32'd2);
        push_item(MODE_ADVANCE, 16'd1000, '0, '0, '0);
        push_item(MODE_ADVANCE, 16'hFFFF, '0, '0, '0);
        push_item(MODE_RESTART, '0, '0, '0, '0);
        wait_drained();

        for (int p = 0; p < 13; p++) begin
            idle_mode = idle_mode_t'(p % 4);
            case (p)
                0, 3:    count = 64;
                1:       count = 0;
                2:       count = 1;
                default: count = ($urandom_range(1) != 0) ? $urandom_range(1, 8)
                                                          : $urandom_range(0, 64);
            endcase
            reg_access(REG_FRAME_COUNT, 32'(count));
            if (p == 1)
                reg_access(REG_BASE_TILE, 32'h0);
            else if (p == 2)
                reg_access(REG_BASE_TILE, 32'hFFFF);
            else
                reg_access(REG_BASE_TILE, 32'($urandom_range(0, 65535)));
            // fresh entries for up to the first 16 frames, sometimes all nonzero so long advances fold
            no_holds = $urandom_range(1);
            reload = (count < 16) ? count : 16;
            for (int s = 0; s < reload; s++)
                push_item(MODE_WRITE, '0, SLOT_W'(s), TILE_W'($urandom),
                          pick_duration(no_holds));
            if ($urandom_range(1) != 0)
                push_item(MODE_RESTART, '0, '0, '0, '0);
            for (int k = 0; k < 100; k++)
                push_random(count);
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("tile_frame_animation_sequencer_unit regression: pass");
        else
            $display("tile_frame_animation_sequencer_unit regression: fail");
        $finish;
    end

endmodule
